### design/ddo_pkg.sv
// shared constants, types and tables for the wheel odometry block
package ddo_pkg;

  localparam int CORDIC_STEPS = 24;
  localparam int TIME_BITS    = 48;

  localparam int MUL_A_W   = 33;
  localparam int MUL_B_W   = 32;
  localparam int MUL_P_W   = MUL_A_W + MUL_B_W;
  localparam int MUL_DIGIT = 4;
  localparam int MUL_STEPS = MUL_B_W / MUL_DIGIT;
  localparam int DIV_W     = 64;

  localparam logic signed [31:0] PI_Q28      = 32'sd843314857;
  localparam logic signed [31:0] HALF_PI_Q28 = 32'sd421657428;
  localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
  localparam logic signed [33:0] ONE_Q30     = 34'sd1073741824;
  localparam logic [31:0]        US_PER_S    = 32'd1000000;

  typedef enum logic [1:0] {
    REG_METERS_PER_TICK = 2'd0,
    REG_INV_TRACK       = 2'd1,
    REG_LEFT_REV        = 2'd2,
    REG_RIGHT_REV       = 2'd3
  } cfg_reg_t;

  function automatic logic [29:0] atan_q30(input logic [4:0] i);
    logic [29:0] r;
    unique case (i)
      5'd0:  r = 30'd843314857;
      5'd1:  r = 30'd497837829;
      5'd2:  r = 30'd263043837;
      5'd3:  r = 30'd133525159;
      5'd4:  r = 30'd67021687;
      5'd5:  r = 30'd33543516;
      5'd6:  r = 30'd16775851;
      5'd7:  r = 30'd8388437;
      5'd8:  r = 30'd4194283;
      5'd9:  r = 30'd2097149;
      5'd10: r = 30'd1048576;
      5'd11: r = 30'd524288;
      5'd12: r = 30'd262144;
      5'd13: r = 30'd131072;
      5'd14: r = 30'd65536;
      5'd15: r = 30'd32768;
      5'd16: r = 30'd16384;
      5'd17: r = 30'd8192;
      5'd18: r = 30'd4096;
      5'd19: r = 30'd2048;
      5'd20: r = 30'd1024;
      5'd21: r = 30'd512;
      5'd22: r = 30'd256;
      5'd23: r = 30'd128;
      5'd24: r = 30'd64;
      5'd25: r = 30'd32;
      5'd26: r = 30'd16;
      5'd27: r = 30'd8;
      5'd28: r = 30'd4;
      5'd29: r = 30'd2;
      5'd30: r = 30'd1;
      default: r = 30'd0;
    endcase
    return r;
  endfunction

endpackage

### design/ddo_mul.sv
// serial unsigned multiplier, one 4-bit digit of b per cycle
module ddo_mul
  import ddo_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [MUL_A_W-1:0] a,
  input  logic [MUL_B_W-1:0] b,
  output logic               done,
  output logic [MUL_P_W-1:0] prod
);

  localparam int SUM_W = MUL_A_W + MUL_DIGIT;
  localparam int CNT_W = $clog2(MUL_STEPS);
  localparam logic [CNT_W-1:0] LAST = CNT_W'(MUL_STEPS - 1);

  logic               busy;
  logic [CNT_W-1:0]   cnt;
  logic [MUL_A_W-1:0] areg;
  logic [MUL_A_W-1:0] hi;
  logic [MUL_B_W-1:0] lo;
  logic [SUM_W-1:0]   sum;

  // add one partial product, then shift the pair right by a digit
  assign sum  = SUM_W'(hi) + SUM_W'(areg) * SUM_W'(lo[MUL_DIGIT-1:0]);
  assign prod = {hi, lo};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        areg <= a;
        hi   <= '0;
        lo   <= b;
      end else if (busy) begin
        hi  <= sum[SUM_W-1:MUL_DIGIT];
        lo  <= {sum[MUL_DIGIT-1:0], lo[MUL_B_W-1:MUL_DIGIT]};
        cnt <= cnt + 1'b1;
        if (cnt == LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

### design/ddo_div.sv
// restoring divider, one quotient bit per cycle
module ddo_div
  import ddo_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DIV_W-1:0] num,
  input  logic [DIV_W-1:0] den,
  output logic             done,
  output logic [DIV_W-1:0] quo
);

  localparam int CNT_W = $clog2(DIV_W);
  localparam logic [CNT_W-1:0] LAST = CNT_W'(DIV_W - 1);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [DIV_W-1:0] dreg;
  logic [DIV_W:0]   rem;
  logic [DIV_W:0]   rem_sh;
  logic             fits;

  assign rem_sh = {rem[DIV_W-1:0], quo[DIV_W-1]};
  assign fits   = rem_sh >= {1'b0, dreg};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        dreg <= den;
        rem  <= '0;
        quo  <= num;
      end else if (busy) begin
        rem <= fits ? rem_sh - {1'b0, dreg} : rem_sh;
        quo <= {quo[DIV_W-2:0], fits};
        cnt <= cnt + 1'b1;
        if (cnt == LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

### design/ddo_cordic.sv
// rotation-mode cordic, one micro-rotation per cycle, cos and sin in q2.30
module ddo_cordic
  import ddo_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [31:0] angle,
  output logic               done,
  output logic signed [31:0] cos_q,
  output logic signed [31:0] sin_q
);

  typedef enum logic [4:0] {
    C_IDLE = 5'b00001,
    C_WRAP = 5'b00010,
    C_FOLD = 5'b00100,
    C_ITER = 5'b01000,
    C_FIN  = 5'b10000
  } cstate_t;

  localparam logic [4:0] LAST_STEP = 5'(CORDIC_STEPS - 1);

  cstate_t            state;
  logic signed [33:0] a;
  logic signed [33:0] x, y, z;
  logic [4:0]         idx;
  logic               flip;
  logic signed [33:0] xs, ys, at, xf, yf;

  assign xs = x >>> idx;
  assign ys = y >>> idx;
  assign at = $signed({4'b0, atan_q30(idx)});
  assign xf = flip ? -x : x;
  assign yf = flip ? -y : y;

  function automatic logic signed [31:0] clamp_unit(input logic signed [33:0] v);
    logic signed [31:0] r;
    if (v > ONE_Q30) r = 32'(ONE_Q30);
    else if (v < -ONE_Q30) r = 32'(-ONE_Q30);
    else r = 32'(v);
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= C_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        C_IDLE: begin
          if (start) begin
            a     <= 34'(angle);
            state <= C_WRAP;
          end
        end
        C_WRAP: begin
          if (a > 34'(PI_Q28)) a <= a - 34'(PI_Q28) - 34'(PI_Q28);
          else if (a < -34'(PI_Q28)) a <= a + 34'(PI_Q28) + 34'(PI_Q28);
          state <= C_FOLD;
        end
        C_FOLD: begin
          // fold into +-pi/2 and negate the result at the end
          if (a > 34'(HALF_PI_Q28)) begin
            z    <= (a - 34'(PI_Q28)) <<< 2;
            flip <= 1'b1;
          end else if (a < -34'(HALF_PI_Q28)) begin
            z    <= (a + 34'(PI_Q28)) <<< 2;
            flip <= 1'b1;
          end else begin
            z    <= a <<< 2;
            flip <= 1'b0;
          end
          x     <= CORDIC_GAIN;
          y     <= '0;
          idx   <= '0;
          state <= C_ITER;
        end
        C_ITER: begin
          if (!z[33]) begin
            x <= x - ys;
            y <= y + xs;
            z <= z - at;
          end else begin
            x <= x + ys;
            y <= y - xs;
            z <= z + at;
          end
          idx <= idx + 1'b1;
          if (idx == LAST_STEP) state <= C_FIN;
        end
        C_FIN: begin
          cos_q <= clamp_unit(xf);
          sin_q <= clamp_unit(yf);
          done  <= 1'b1;
          state <= C_IDLE;
        end
        default: state <= C_IDLE;
      endcase
    end
  end

  property p_start_idle;
    @(posedge clk) disable iff (rst) start |-> state == C_IDLE;
  endproperty
  a_start_idle: assert property (p_start_idle) else $error("cordic start while busy");

  property p_out_range;
    @(posedge clk) disable iff (rst)
      done |-> (cos_q <= 32'(ONE_Q30)) && (cos_q >= 32'(-ONE_Q30)) &&
               (sin_q <= 32'(ONE_Q30)) && (sin_q >= 32'(-ONE_Q30));
  endproperty
  a_out_range: assert property (p_out_range) else $error("cordic result out of range");

  property p_done_pulse;
    @(posedge clk) disable iff (rst) done |=> !done;
  endproperty
  a_done_pulse: assert property (p_done_pulse) else $error("cordic done held");

endmodule

### design/differential_drive_odometry_top.sv
// differential drive odometry: sequencer over shared multiplier, divider and cordic
// a moving sample runs up to 7 serial multiplies, 2 divides and 2 cordic passes,
// a seeding or stationary sample only the quaternion cordic pass; one request
// in flight at a time
// a finished result waits in the output register while the next request is taken
// synchronous reset clears pose, speeds, previous samples, seeded flag and out_valid, and loads config defaults
module differential_drive_odometry_top
  import ddo_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [1:0]           cfg_index,
  input  logic [31:0]          cfg_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic signed [31:0]   left_ticks,
  input  logic signed [31:0]   right_ticks,
  input  logic [TIME_BITS-1:0] sample_time_us,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic signed [31:0]   pos_x,
  output logic signed [31:0]   pos_y,
  output logic signed [30:0]   heading,
  output logic signed [31:0]   linear_speed,
  output logic signed [31:0]   turn_rate,
  output logic signed [31:0]   quat_z,
  output logic signed [31:0]   quat_w,
  output logic                 seed_only
);

  typedef enum logic [12:0] {
    S_IDLE = 13'b0000000000001,
    S_ML   = 13'b0000000000010,
    S_MR   = 13'b0000000000100,
    S_MTH  = 13'b0000000001000,
    S_CMID = 13'b0000000010000,
    S_MX   = 13'b0000000100000,
    S_MY   = 13'b0000001000000,
    S_MSP  = 13'b0000010000000,
    S_DSP  = 13'b0000100000000,
    S_MTR  = 13'b0001000000000,
    S_DTR  = 13'b0010000000000,
    S_QUAT = 13'b0100000000000,
    S_OUT  = 13'b1000000000000
  } state_t;

  state_t state;
  logic   issued;

  logic [31:0] mpt, itw;
  logic        lrev, rrev;

  logic signed [31:0]   pose_x, pose_y, speed, turn;
  logic signed [30:0]   pose_hd;
  logic [31:0]          last_l, last_r;
  logic [TIME_BITS-1:0] last_t;
  logic                 seeded;

  logic [TIME_BITS-1:0] dt;
  logic signed [32:0]   dl, dr;
  logic signed [31:0]   ld, rd, ds, mid_c, mid_s;
  logic signed [30:0]   dth;
  logic                 seed;

  // accept-time differences
  logic                 in_acc;
  logic [31:0]          lraw, rraw;
  logic [TIME_BITS-1:0] dt_now;
  logic signed [32:0]   dl_now, dr_now;

  assign in_acc = in_valid && !in_stall;
  assign in_stall = (state != S_IDLE);
  assign lraw   = left_ticks - last_l;
  assign rraw   = right_ticks - last_r;
  assign dt_now = sample_time_us - last_t;
  assign dl_now = lrev ? 33'sd0 - $signed({lraw[31], lraw}) : $signed({lraw[31], lraw});
  assign dr_now = rrev ? 33'sd0 - $signed({rraw[31], rraw}) : $signed({rraw[31], rraw});

  function automatic logic [32:0] mag33(input logic signed [32:0] v);
    return v[32] ? 33'(-v) : 33'(v);
  endfunction

  function automatic logic signed [31:0] sat_sm(input logic neg, input logic [63:0] m);
    logic signed [31:0] r;
    if (neg) r = (m > 64'h8000_0000) ? 32'sh8000_0000 : 32'(64'd0 - m);
    else r = (m > 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF : 32'(m);
    return r;
  endfunction

  function automatic logic signed [31:0] sat36(input logic signed [35:0] v);
    logic signed [31:0] r;
    if (v > 36'sh0_7FFF_FFFF) r = 32'sh7FFF_FFFF;
    else if (v < -36'sh0_8000_0000) r = 32'sh8000_0000;
    else r = 32'(v);
    return r;
  endfunction

  function automatic logic signed [31:0] half31(input logic signed [30:0] v);
    logic signed [31:0] t;
    t = 32'(v) + $signed({31'd0, v[30]});
    return t >>> 1;
  endfunction

  // shared units
  logic               mul_start, mul_done;
  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic [MUL_P_W-1:0] mul_p;
  logic               div_start, div_done;
  logic [DIV_W-1:0]   div_num, div_den, div_q;
  logic               cor_start, cor_done;
  logic signed [31:0] cor_angle, cor_c, cor_s;
  logic               long_dt;
  logic signed [32:0] diff_lr;

  assign long_dt = |(64'(dt) >> 51);
  assign diff_lr = 33'(rd) - 33'(ld);

  always_comb begin
    mul_start = 1'b0;
    cor_start = 1'b0;
    div_start = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    cor_angle = half31(pose_hd);
    unique case (state)
      S_ML: begin mul_start = !issued; mul_a = mag33(dl); mul_b = mpt; end
      S_MR: begin mul_start = !issued; mul_a = mag33(dr); mul_b = mpt; end
      S_MTH: begin mul_start = !issued; mul_a = mag33(diff_lr); mul_b = itw; end
      S_CMID: begin
        cor_start = !issued;
        cor_angle = 32'(pose_hd) + half31(dth);
      end
      S_MX: begin
        mul_start = !issued;
        mul_a = mag33(33'(ds));
        mul_b = 32'(mag33(33'(mid_c)));
      end
      S_MY: begin
        mul_start = !issued;
        mul_a = mag33(33'(ds));
        mul_b = 32'(mag33(33'(mid_s)));
      end
      S_MSP: begin mul_start = !issued; mul_a = mag33(33'(ds)); mul_b = US_PER_S; end
      S_DSP: div_start = !issued;
      S_MTR: begin
        mul_start = !issued && !long_dt;
        mul_a = mag33(33'(dth));
        mul_b = US_PER_S;
      end
      S_DTR: div_start = !issued;
      S_QUAT: cor_start = !issued;
      default: ;
    endcase
  end

  ddo_mul u_mul (
    .clk(clk), .rst(rst), .start(mul_start), .a(mul_a), .b(mul_b),
    .done(mul_done), .prod(mul_p)
  );

  ddo_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .num(div_num), .den(div_den),
    .done(div_done), .quo(div_q)
  );

  ddo_cordic u_cordic (
    .clk(clk), .rst(rst), .start(cor_start), .angle(cor_angle),
    .done(cor_done), .cos_q(cor_c), .sin_q(cor_s)
  );

  // rounded magnitudes out of the multiplier
  logic [48:0]        rnd16;
  logic [52:0]        rnd12;
  logic [34:0]        rnd30;
  logic [30:0]        dth_mag;
  logic signed [32:0] ds_sum;
  logic signed [35:0] step_v, sum_x, sum_y;
  logic signed [31:0] hd_sum;

  assign rnd16   = 49'(mul_p[64:16]) + 49'(mul_p[15]);
  assign rnd12   = 53'(mul_p[64:12]) + 53'(mul_p[11]);
  assign rnd30   = 35'(mul_p[64:30]) + 35'(mul_p[29]);
  assign dth_mag = (rnd12 > 53'(PI_Q28)) ? 31'(PI_Q28) : rnd12[30:0];
  assign ds_sum  = 33'(ld) + 33'(rd);
  assign step_v  = (ds[31] ^ (state == S_MX ? mid_c[31] : mid_s[31]))
                   ? 36'sd0 - $signed({1'b0, rnd30}) : $signed({1'b0, rnd30});
  assign sum_x   = 36'(pose_x) + step_v;
  assign sum_y   = 36'(pose_y) + step_v;
  assign hd_sum  = 32'(pose_hd) + 32'(dth);

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      issued  <= 1'b0;
      mpt     <= 32'd907200;
      itw     <= 32'd104857600;
      lrev    <= 1'b0;
      rrev    <= 1'b0;
      pose_x  <= '0;
      pose_y  <= '0;
      pose_hd <= '0;
      speed   <= '0;
      turn    <= '0;
      last_l  <= '0;
      last_r  <= '0;
      last_t  <= '0;
      seeded  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_reg_t'(cfg_index))
          REG_METERS_PER_TICK: mpt  <= cfg_data;
          REG_INV_TRACK:       itw  <= cfg_data;
          REG_LEFT_REV:        lrev <= cfg_data[0];
          REG_RIGHT_REV:       rrev <= cfg_data[0];
          default: ;
        endcase
      end

      if (mul_start || div_start || cor_start) issued <= 1'b1;
      if (mul_done || div_done || cor_done) issued <= 1'b0;

      // a result loaded in S_OUT this cycle sets the flag there
      if (out_valid && !out_stall && state != S_OUT) out_valid <= 1'b0;

      unique case (state)
        S_IDLE: begin
          if (in_acc) begin
            last_l <= left_ticks;
            last_r <= right_ticks;
            last_t <= sample_time_us;
            dt     <= dt_now;
            dl     <= dl_now;
            dr     <= dr_now;
            seed   <= !seeded;
            seeded <= 1'b1;
            // a seeding sample, or stationary or backward time, leaves the pose alone
            if (!seeded || dt_now == '0 || dt_now[TIME_BITS-1]) state <= S_QUAT;
            else state <= S_ML;
          end
        end
        S_ML: if (mul_done) begin
          ld    <= sat_sm(dl[32], 64'(rnd16));
          state <= S_MR;
        end
        S_MR: if (mul_done) begin
          rd    <= sat_sm(dr[32], 64'(rnd16));
          state <= S_MTH;
        end
        S_MTH: if (mul_done) begin
          dth   <= diff_lr[32] ? 31'(31'd0 - dth_mag) : dth_mag;
          // mean advance, truncated toward zero
          ds    <= 32'((ds_sum + $signed({32'd0, ds_sum[32]})) >>> 1);
          state <= S_CMID;
        end
        S_CMID: if (cor_done) begin
          mid_c <= cor_c;
          mid_s <= cor_s;
          state <= S_MX;
        end
        S_MX: if (mul_done) begin
          pose_x <= sat36(sum_x);
          state  <= S_MY;
        end
        S_MY: if (mul_done) begin
          pose_y <= sat36(sum_y);
          if (hd_sum > PI_Q28) pose_hd <= 31'(hd_sum - PI_Q28 - PI_Q28);
          else if (hd_sum < -PI_Q28) pose_hd <= 31'(hd_sum + PI_Q28 + PI_Q28);
          else pose_hd <= 31'(hd_sum);
          state <= S_MSP;
        end
        S_MSP: if (mul_done) begin
          div_num <= mul_p[DIV_W-1:0] + 64'(dt >> 1);
          div_den <= 64'(dt);
          state   <= S_DSP;
        end
        S_DSP: if (div_done) begin
          speed <= sat_sm(ds[31], div_q);
          state <= S_MTR;
        end
        S_MTR: begin
          if (long_dt) begin
            turn  <= '0;
            state <= S_QUAT;
          end else if (mul_done) begin
            div_num <= mul_p[DIV_W-1:0] + (64'(dt) << 11);
            div_den <= 64'(dt) << 12;
            state   <= S_DTR;
          end
        end
        S_DTR: if (div_done) begin
          turn  <= sat_sm(dth[30], div_q);
          state <= S_QUAT;
        end
        S_QUAT: if (cor_done) state <= S_OUT;
        S_OUT: begin
          if (!out_valid || !out_stall) begin
            pos_x        <= pose_x;
            pos_y        <= pose_y;
            heading      <= pose_hd;
            linear_speed <= speed;
            turn_rate    <= turn;
            quat_z       <= cor_s;
            quat_w       <= cor_c;
            seed_only    <= seed;
            out_valid    <= 1'b1;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  property p_heading_range;
    @(posedge clk) disable iff (rst)
      out_valid |-> (heading <= 31'(PI_Q28)) && (heading >= 31'(-PI_Q28));
  endproperty
  a_heading_range: assert property (p_heading_range) else $error("heading out of range");

  property p_unit_done_issued;
    @(posedge clk) disable iff (rst) (mul_done || div_done || cor_done) |-> issued;
  endproperty
  a_unit_done_issued: assert property (p_unit_done_issued) else $error("unexpected unit done");

  property p_one_start;
    @(posedge clk) disable iff (rst)
      $countones({mul_start, div_start, cor_start}) <= 1;
  endproperty
  a_one_start: assert property (p_one_start) else $error("two units started");

  property p_busy_after_accept;
    @(posedge clk) disable iff (rst) in_acc |=> in_stall;
  endproperty
  a_busy_after_accept: assert property (p_busy_after_accept) else $error("accepted twice");

endmodule
